>>> hw/rtl/adf_pkg.sv
// ----------------------------------------------------------------------------
// adf_pkg
// Shared types and constants for the ADTS frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package adf_pkg;

   localparam logic [7:0]  SYNC_HI       = 8'hFF;
   localparam logic [3:0]  SYNC_LO       = 4'hF;
   localparam logic [12:0] HDR_LEN       = 13'd7;
   localparam logic [2:0]  HDR_LAST_IDX  = 3'd6;

   typedef enum logic [2:0] {
      EV_HDR_BYTE  = 3'd0,
      EV_HDR_OK    = 3'd1,
      EV_PAYLOAD   = 3'd2,
      EV_LAST      = 3'd3,
      EV_SYNC_ERR  = 3'd4,
      EV_LEN_ERR   = 3'd5,
      EV_END       = 3'd6,
      EV_HDR_ONLY  = 3'd7
   } event_type;

   typedef struct packed {
      logic [12:0] frame_bytes;
      logic [3:0]  rate_index;
      logic [1:0]  audio_profile;
      logic [2:0]  channel_setup;
      logic        crc_absent;
      logic [10:0] fullness;
      logic [1:0]  raw_blocks;
      logic [7:0]  misc_flags;
   } hdr_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  payload_byte;
      hdr_type     hdr;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/adf_hdr_unpack.sv
// ----------------------------------------------------------------------------
// adf_hdr_unpack
// Checks the sync word of a seven byte ADTS header and unpacks its fields.
// ----------------------------------------------------------------------------
`default_nettype none

module adf_hdr_unpack (
   input  wire logic [47:0]      hdr_bytes,
   input  wire logic [7:0]       last_byte,
   output logic                  sync_ok,
   output adf_pkg::hdr_type      fields
);
   import adf_pkg::*;

   logic [7:0] b0, b1, b2, b3, b4, b5, b6;

   assign b0 = hdr_bytes[47:40];
   assign b1 = hdr_bytes[39:32];
   assign b2 = hdr_bytes[31:24];
   assign b3 = hdr_bytes[23:16];
   assign b4 = hdr_bytes[15:8];
   assign b5 = hdr_bytes[7:0];
   assign b6 = last_byte;

   assign sync_ok = (b0 == SYNC_HI) && (b1[7:4] == SYNC_LO);

   always_comb begin
      fields.frame_bytes   = {b3[1:0], b4, b5[7:5]};
      fields.rate_index    = b2[5:2];
      fields.audio_profile = b2[7:6];
      fields.channel_setup = {b2[0], b3[7:6]};
      fields.crc_absent    = b1[0];
      fields.fullness      = {b5[4:0], b6[7:2]};
      fields.raw_blocks    = b6[1:0];
      fields.misc_flags    = {b1[3], b1[2:1], b2[1], b3[5], b3[4], b3[3], b3[2]};
   end

endmodule

`default_nettype wire

>>> hw/rtl/adf_core.sv
// ----------------------------------------------------------------------------
// adf_core
// Header hunt and payload count; forms one result per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module adf_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [7:0]       stream_byte,
   input  wire logic             stream_end,
   output adf_pkg::rsp_type      res
);
   import adf_pkg::*;

   typedef enum logic {
      ST_HUNT    = 1'b0,
      ST_PAYLOAD = 1'b1
   } state_type;

   state_type   st_ff, st_in;
   logic [2:0]  count_ff, count_in;
   logic [47:0] store_ff, store_in;
   logic [12:0] left_ff, left_in;
   hdr_type     held_ff, held_in;

   logic        sync_ok;
   hdr_type     unp;
   logic        last;

   adf_hdr_unpack u_unpack (
      .hdr_bytes (store_ff),
      .last_byte (stream_byte),
      .sync_ok   (sync_ok),
      .fields    (unp)
   );

   assign last = (left_ff <= 13'd1);

   always_comb begin
      st_in            = st_ff;
      count_in         = count_ff;
      store_in         = store_ff;
      left_in          = left_ff;
      held_in          = held_ff;
      res.event_res    = EV_HDR_BYTE;
      res.payload_byte = '0;
      res.hdr          = '0;
      if (stream_end) begin
         if (st_ff == ST_HUNT && count_ff == 3'd0) begin
            res.event_res = EV_END;
         end else begin
            st_in         = ST_HUNT;
            count_in      = 3'd0;
            left_in       = '0;
            res.event_res = EV_LEN_ERR;
         end
      end else if (st_ff == ST_PAYLOAD) begin
         res.payload_byte = stream_byte;
         res.hdr          = held_ff;
         if (last) begin
            left_in       = '0;
            st_in         = ST_HUNT;
            count_in      = 3'd0;
            res.event_res = EV_LAST;
         end else begin
            left_in       = left_ff - 13'd1;
            res.event_res = EV_PAYLOAD;
         end
      end else if (count_ff < HDR_LAST_IDX) begin
         store_in = {store_ff[39:0], stream_byte};
         count_in = count_ff + 3'd1;
      end else begin
         count_in = 3'd0;
         store_in = '0;
         if (!sync_ok) begin
            res.event_res = EV_SYNC_ERR;
         end else begin
            held_in = unp;
            res.hdr = unp;
            if (unp.frame_bytes < HDR_LEN) begin
               res.event_res = EV_LEN_ERR;
            end else if (unp.frame_bytes == HDR_LEN) begin
               res.event_res = EV_HDR_ONLY;
            end else begin
               st_in         = ST_PAYLOAD;
               left_in       = unp.frame_bytes - HDR_LEN;
               res.event_res = EV_HDR_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_HUNT;
         count_ff <= 3'd0;
         left_ff  <= '0;
      end else if (take) begin
         st_ff    <= st_in;
         count_ff <= count_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         store_ff <= store_in;
         held_ff  <= held_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HDR_LAST_IDX)
      else $error("header count out of range");

   a_hdr_ok_enters_payload: assert property (@(posedge clock) disable iff (reset)
      (take && res.event_res == EV_HDR_OK) |=> (st_ff == ST_PAYLOAD))
      else $error("header ok did not start payload");

   a_payload_has_frame: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_PAYLOAD) |-> (held_ff.frame_bytes > HDR_LEN &&
                                 left_ff != 13'd0 && count_ff == 3'd0))
      else $error("payload state without a valid frame");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/adf_out_queue.sv
// ----------------------------------------------------------------------------
// adf_out_queue
// Two entry result buffer; keeps input acceptance going while a beat waits.
// ----------------------------------------------------------------------------
`default_nettype none

module adf_out_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire adf_pkg::rsp_type push_data,
   output logic                  not_full,
   output logic                  head_valid,
   input  wire logic             pop,
   output adf_pkg::rsp_type      head
);
   import adf_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    q0_ff, q1_ff;

   assign not_full   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = q0_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !pop) begin
         if (count_ff == 2'd0) begin
            q0_ff <= push_data;
         end else begin
            q1_ff <= push_data;
         end
      end else if (pop && !push) begin
         q0_ff <= q1_ff;
      end else if (pop && push) begin
         if (count_ff == 2'd1) begin
            q0_ff <= push_data;
         end else begin
            q0_ff <= q1_ff;
            q1_ff <= push_data;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer overflow");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("push into full result buffer");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/adts_frame_deframer.sv
// ----------------------------------------------------------------------------
// adts_frame_deframer
// ADTS byte stream deframer: header capture, sync check, field unpack and
// payload pass-through with last-byte marking.
// ----------------------------------------------------------------------------
//  channel | ports                         | dir | handshake
//  --------+-------------------------------+-----+--------------------------
//  request | req_stream_byte, req_stream_end | in  | req_valid / req_ready
//  result  | rsp_event_res .. rsp_misc_flags | out | rsp_valid / rsp_ready
//
//  one beat in gives one beat out, registered in the result buffer
//  sustained rate is one beat per cycle while results are taken; the state
//  update is single pass; with one result waiting, a result stall fills the
//  second entry and drops req_ready from the next cycle
//  req_ready falls only while both result entries are occupied
//  synchronous reset returns to header hunt and empties the result buffer
// ----------------------------------------------------------------------------
`default_nettype none

module adts_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_stream_byte,
   input  wire logic        req_stream_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_event_res,
   output logic [7:0]       rsp_payload_byte,
   output logic [12:0]      rsp_frame_bytes,
   output logic [3:0]       rsp_rate_index,
   output logic [1:0]       rsp_audio_profile,
   output logic [2:0]       rsp_channel_setup,
   output logic             rsp_crc_absent,
   output logic [10:0]      rsp_fullness,
   output logic [1:0]       rsp_raw_blocks,
   output logic [7:0]       rsp_misc_flags
);
   import adf_pkg::*;

   logic    take;
   logic    not_full;
   rsp_type res;
   rsp_type head;

   assign req_ready = not_full;
   assign take      = req_valid && not_full;

   adf_core u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .stream_byte (req_stream_byte),
      .stream_end  (req_stream_end),
      .res         (res)
   );

   adf_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (take),
      .push_data  (res),
      .not_full   (not_full),
      .head_valid (rsp_valid),
      .pop        (rsp_valid && rsp_ready),
      .head       (head)
   );

   assign rsp_event_res     = head.event_res;
   assign rsp_payload_byte  = head.payload_byte;
   assign rsp_frame_bytes   = head.hdr.frame_bytes;
   assign rsp_rate_index    = head.hdr.rate_index;
   assign rsp_audio_profile = head.hdr.audio_profile;
   assign rsp_channel_setup = head.hdr.channel_setup;
   assign rsp_crc_absent    = head.hdr.crc_absent;
   assign rsp_fullness      = head.hdr.fullness;
   assign rsp_raw_blocks    = head.hdr.raw_blocks;
   assign rsp_misc_flags    = head.hdr.misc_flags;

endmodule

`default_nettype wire

>>> tb/adts_frame_deframer_test.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// adts_frame_deframer_test
// Self-checking bench for the ADTS deframer. A short table of headers, frames
// and error cases runs first, then a long mix of well-formed frames with random
// fields and lengths, truncated frames, broken headers, stray bytes and end
// markers. Every result beat is checked field by field against a beat-level
// parser model or typed table row, under random idling or none on both sides.
// ----------------------------------------------------------------------------
module adts_frame_deframer_test;
   import adf_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_BEATS = 370;
   localparam int REPORT_MAX  = 10;
   localparam int NUM_ROWS    = 26;

   typedef struct packed {
      logic [7:0] data;
      logic       stop;
      logic       typed;
      event_type  ev;
   } table_row_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        req_stream_end  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_payload_byte;
   logic [12:0] rsp_frame_bytes;
   logic [3:0]  rsp_rate_index;
   logic [1:0]  rsp_audio_profile;
   logic [2:0]  rsp_channel_setup;
   logic        rsp_crc_absent;
   logic [10:0] rsp_fullness;
   logic [1:0]  rsp_raw_blocks;
   logic [7:0]  rsp_misc_flags;

   // parser model state
   logic        mdl_in_payload = 1'b0;
   logic [2:0]  mdl_hdr_count  = 3'd0;
   logic [47:0] mdl_hdr_bytes  = '0;
   logic [12:0] mdl_bytes_left = '0;
   hdr_type     mdl_hdr        = '0;

   rsp_type     pending_results [$];
   rsp_type     got_result;
   rsp_type     want_result;
   int          beats_in       = 0;
   int          results_seen   = 0;
   int          mismatches     = 0;
   int          event_seen [8] = '{default: 0};
   int          req_idle_pct   = 29;
   int          rsp_idle_pct   = 54;
   int          quiet_cycles   = 0;
   int          hold_left      = 0;
   logic        hold_go        = 1'b0;
   logic        hold_used      = 1'b0;

   table_row_type directed_rows [NUM_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, EV_END},
      // bad sync nibble
      '{8'hFF, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h0F, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h12, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h34, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h56, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h78, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h9A, 1'b0, 1'b1, EV_SYNC_ERR},
      // header-only frame, every other field at its top value
      '{8'hFF, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'hFF, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'hFF, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'hFC, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h00, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'hFF, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'hFF, 1'b0, 1'b0, EV_HDR_BYTE},
      // nine byte frame, two payload beats
      '{8'hFF, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'hF1, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h50, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h80, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h01, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h20, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h00, 1'b0, 1'b0, EV_HDR_BYTE},
      '{8'h00, 1'b0, 1'b0, EV_HDR_BYTE},
      '{8'hFF, 1'b0, 1'b0, EV_HDR_BYTE},
      // stream ends inside a header
      '{8'hFF, 1'b0, 1'b1, EV_HDR_BYTE},
      '{8'h00, 1'b1, 1'b1, EV_LEN_ERR}
   };

   adts_frame_deframer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_byte   (req_stream_byte),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_frame_bytes   (rsp_frame_bytes),
      .rsp_rate_index    (rsp_rate_index),
      .rsp_audio_profile (rsp_audio_profile),
      .rsp_channel_setup (rsp_channel_setup),
      .rsp_crc_absent    (rsp_crc_absent),
      .rsp_fullness      (rsp_fullness),
      .rsp_raw_blocks    (rsp_raw_blocks),
      .rsp_misc_flags    (rsp_misc_flags)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type deframe_beat(logic [7:0] data, logic stop);
      rsp_type    r;
      logic [7:0] b0, b1, b2, b3, b4, b5;
      logic       last;
      r = '0;
      if (stop) begin
         if (!mdl_in_payload && mdl_hdr_count == 3'd0) begin
            r.event_res = EV_END;
         end else begin
            mdl_in_payload = 1'b0;
            mdl_hdr_count  = 3'd0;
            mdl_bytes_left = '0;
            r.event_res    = EV_LEN_ERR;
         end
      end else if (mdl_in_payload) begin
         last           = mdl_bytes_left <= 13'd1;
         mdl_bytes_left = last ? 13'd0 : mdl_bytes_left - 13'd1;
         if (last) begin
            mdl_in_payload = 1'b0;
            mdl_hdr_count  = 3'd0;
         end
         r.event_res    = last ? EV_LAST : EV_PAYLOAD;
         r.payload_byte = data;
         r.hdr          = mdl_hdr;
      end else if (mdl_hdr_count < HDR_LAST_IDX) begin
         mdl_hdr_bytes = {mdl_hdr_bytes[39:0], data};
         mdl_hdr_count = mdl_hdr_count + 3'd1;
         r.event_res   = EV_HDR_BYTE;
      end else begin
         {b0, b1, b2, b3, b4, b5} = mdl_hdr_bytes;
         mdl_hdr_count = 3'd0;
         mdl_hdr_bytes = '0;
         if (b0 != SYNC_HI || b1[7:4] != SYNC_LO) begin
            r.event_res = EV_SYNC_ERR;
         end else begin
            mdl_hdr.frame_bytes   = {b3[1:0], b4, b5[7:5]};
            mdl_hdr.rate_index    = b2[5:2];
            mdl_hdr.audio_profile = b2[7:6];
            mdl_hdr.channel_setup = {b2[0], b3[7:6]};
            mdl_hdr.crc_absent    = b1[0];
            mdl_hdr.fullness      = {b5[4:0], data[7:2]};
            mdl_hdr.raw_blocks    = data[1:0];
            mdl_hdr.misc_flags    = {b1[3], b1[2:1], b2[1], b3[5], b3[4], b3[3], b3[2]};
            r.hdr                 = mdl_hdr;
            if (mdl_hdr.frame_bytes < HDR_LEN) begin
               r.event_res = EV_LEN_ERR;
            end else if (mdl_hdr.frame_bytes == HDR_LEN) begin
               r.event_res = EV_HDR_ONLY;
            end else begin
               mdl_in_payload = 1'b1;
               mdl_bytes_left = mdl_hdr.frame_bytes - HDR_LEN;
               r.event_res    = EV_HDR_OK;
            end
         end
      end
      return r;
   endfunction

   task automatic send_beat(logic [7:0] data, logic stop, logic typed = 1'b0,
                            event_type ev = EV_HDR_BYTE);
      rsp_type model_out;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= data;
      req_stream_end  <= stop;
      do @(posedge clock); while (req_ready !== 1'b1);
      beats_in++;
      model_out = deframe_beat(data, stop);
      if (typed) begin
         model_out           = '0;
         model_out.event_res = ev;
      end
      pending_results.push_back(model_out);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic stream_mix(int stop_at);
      int         pick, flen, cut, sent;
      logic [7:0] hdr [7];
      while (beats_in < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // resync with an end marker if the parser is mid header or frame
            if (mdl_in_payload || mdl_hdr_count != 3'd0) send_beat(8'($urandom), 1'b1);
            pick = $urandom_range(0, 99);
            if (pick < 8) flen = $urandom_range(0, 6);
            else if (pick < 16) flen = 7;
            else if (pick < 17) flen = 8191;
            else if (pick < 19) flen = $urandom_range(4096, 8190);
            else flen = $urandom_range(8, 48);
            cut = (flen > 48 || $urandom_range(0, 99) < 8) ? $urandom_range(0, 20) : -1;
            hdr[0] = SYNC_HI;
            hdr[1] = {SYNC_LO, 4'($urandom)};
            hdr[2] = 8'($urandom);
            hdr[3] = {6'($urandom), 2'(flen >> 11)};
            hdr[4] = 8'(flen >> 3);
            hdr[5] = {3'(flen), 5'($urandom)};
            hdr[6] = 8'($urandom);
            for (int i = 0; i < 7; i++) send_beat(hdr[i], 1'b0);
            for (sent = 0; sent < flen - 7 && sent != cut; sent++)
               send_beat(8'($urandom), 1'b0);
            if (sent == cut) send_beat(8'($urandom), 1'b1);
         end else if (pick < 75) begin
            send_beat(8'($urandom), 1'b0);
         end else if (pick < 83) begin
            send_beat(8'($urandom), 1'b1);
         end else if (pick < 93) begin
            for (int i = 0; i < 7; i++) send_beat(8'($urandom), 1'b0);
         end else begin
            cut = $urandom_range(1, 6);
            send_beat(SYNC_HI, 1'b0);
            for (int i = 1; i < cut; i++) send_beat(8'($urandom), 1'b0);
            send_beat(8'($urandom), 1'b1);
         end
      end
   endtask

   task automatic note_mismatch(string what, logic [12:0] want, logic [12:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("mismatch at %0t on %s: expected %0h, got %0h", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            note_mismatch("result beat with nothing pending", '0, 13'(rsp_event_res));
         end else begin
            want_result = pending_results.pop_front();
            event_seen[int'(want_result.event_res)]++;
            got_result.event_res         = event_type'(rsp_event_res);
            got_result.payload_byte      = rsp_payload_byte;
            got_result.hdr.frame_bytes   = rsp_frame_bytes;
            got_result.hdr.rate_index    = rsp_rate_index;
            got_result.hdr.audio_profile = rsp_audio_profile;
            got_result.hdr.channel_setup = rsp_channel_setup;
            got_result.hdr.crc_absent    = rsp_crc_absent;
            got_result.hdr.fullness      = rsp_fullness;
            got_result.hdr.raw_blocks    = rsp_raw_blocks;
            got_result.hdr.misc_flags    = rsp_misc_flags;
            if (got_result.event_res !== want_result.event_res)
               note_mismatch("event_res", 13'(want_result.event_res),
                             13'(got_result.event_res));
            if (got_result.payload_byte !== want_result.payload_byte)
               note_mismatch("payload_byte", 13'(want_result.payload_byte),
                             13'(got_result.payload_byte));
            if (got_result.hdr.frame_bytes !== want_result.hdr.frame_bytes)
               note_mismatch("frame_bytes", want_result.hdr.frame_bytes,
                             got_result.hdr.frame_bytes);
            if (got_result.hdr.rate_index !== want_result.hdr.rate_index)
               note_mismatch("rate_index", 13'(want_result.hdr.rate_index),
                             13'(got_result.hdr.rate_index));
            if (got_result.hdr.audio_profile !== want_result.hdr.audio_profile)
               note_mismatch("audio_profile", 13'(want_result.hdr.audio_profile),
                             13'(got_result.hdr.audio_profile));
            if (got_result.hdr.channel_setup !== want_result.hdr.channel_setup)
               note_mismatch("channel_setup", 13'(want_result.hdr.channel_setup),
                             13'(got_result.hdr.channel_setup));
            if (got_result.hdr.crc_absent !== want_result.hdr.crc_absent)
               note_mismatch("crc_absent", 13'(want_result.hdr.crc_absent),
                             13'(got_result.hdr.crc_absent));
            if (got_result.hdr.fullness !== want_result.hdr.fullness)
               note_mismatch("fullness", 13'(want_result.hdr.fullness),
                             13'(got_result.hdr.fullness));
            if (got_result.hdr.raw_blocks !== want_result.hdr.raw_blocks)
               note_mismatch("raw_blocks", 13'(want_result.hdr.raw_blocks),
                             13'(got_result.hdr.raw_blocks));
            if (got_result.hdr.misc_flags !== want_result.hdr.misc_flags)
               note_mismatch("misc_flags", 13'(want_result.hdr.misc_flags),
                             13'(got_result.hdr.misc_flags));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no beat moved for %0d cycles", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sender 29, receiver 54
      foreach (directed_rows[i])
         send_beat(directed_rows[i].data, directed_rows[i].stop,
                   directed_rows[i].typed, directed_rows[i].ev);
      stream_mix(beats_in + PHASE_BEATS);
      wait_for_results();

      // swapped idling
      req_idle_pct = 54;
      rsp_idle_pct = 29;
      stream_mix(beats_in + PHASE_BEATS);
      wait_for_results();

      // no idling, receiver holds off once so the input backs up
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_go <= 1'b1;
      stream_mix(beats_in + PHASE_BEATS);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d stream beats in, %0d result beats checked, %0d field mismatches",
               beats_in, results_seen, mismatches);
      $display("events hdr %0d ok %0d pay %0d last %0d sync %0d len %0d end %0d only %0d",
               event_seen[0], event_seen[1], event_seen[2], event_seen[3],
               event_seen[4], event_seen[5], event_seen[6], event_seen[7]);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> adts_frame_deframer.f
hw/rtl/adf_pkg.sv
hw/rtl/adf_hdr_unpack.sv
hw/rtl/adf_core.sv
hw/rtl/adf_out_queue.sv
hw/rtl/adts_frame_deframer.sv
tb/adts_frame_deframer_test.sv
